// ----- hw/rtl/sit_pkg.sv -----
package sit_pkg;

  // field and counter widths
  localparam int unsigned IDX_W    = 11;
  localparam int unsigned CNT_W    = 12;
  localparam int unsigned LFSR_W   = 10;
  localparam int unsigned CANDIDATES = 2048;

  // lfsr start value and the last candidate of the build
  localparam logic [LFSR_W-1:0] LFSR_SEED = 10'h001;
  localparam logic [CNT_W-1:0]  LAST_CAND = 12'(CANDIDATES - 1);

  // destination bit of each R' bit in the scrambled address
  localparam logic [3:0] BIT_DEST [LFSR_W] = '{
    4'd4, 4'd3, 4'd9, 4'd6, 4'd2, 4'd8, 4'd1, 4'd5, 4'd7, 4'd0
  };

  // write requests from the table builder to both memories
  typedef struct packed {
    logic             fwd_we;
    logic [IDX_W-1:0] fwd_addr;
    logic [IDX_W-1:0] fwd_data;
    logic             inv_we;
    logic [IDX_W-1:0] inv_addr;
    logic [IDX_W-1:0] inv_data;
  } sit_wr_t;

  // fixed bit permutation of R'
  function automatic logic [LFSR_W-1:0] scramble_bits(input logic [LFSR_W-1:0] r);
    logic [LFSR_W-1:0] v;
    v = '0;
    for (int b = 0; b < LFSR_W; b++) begin
      v[BIT_DEST[b]] = r[b];
    end
    return v;
  endfunction

endpackage

// ----- hw/rtl/sit_ram.sv -----
module sit_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1512,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_W-1:0]      waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   re,
  input  logic [ADDR_W-1:0]      raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/sit_builder.sv -----
module sit_builder
  import sit_pkg::*;
#(
  parameter int unsigned DATA_CELLS = 1512
) (
  input  logic    clk,
  input  logic    rst_n,
  output sit_wr_t wr,
  output logic    tables_ready
);

  localparam logic [CNT_W-1:0] CELLS_W = CNT_W'(DATA_CELLS);

  logic [CNT_W-1:0]  cand_r, cand_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic              ready_r, ready_nxt;

  logic              building;
  logic [LFSR_W-1:0] lfsr_step;
  logic [LFSR_W-1:0] rprime;
  logic [IDX_W-1:0]  cand_addr;
  logic              take;

  // one candidate per cycle until all have been tried
  always_comb begin
    building  = !ready_r;
    lfsr_step = {lfsr_r[0] ^ lfsr_r[3], lfsr_r[LFSR_W-1:1]};

    // R' is zero for the first two candidates, one for the third, then the lfsr
    priority if (cand_r < CNT_W'(2)) begin
      rprime = '0;
    end else if (cand_r == CNT_W'(2)) begin
      rprime = LFSR_W'(1);
    end else begin
      rprime = lfsr_step;
    end

    cand_addr = {cand_r[0], scramble_bits(rprime)};
    take      = building && ({1'b0, cand_addr} < CELLS_W) && (acc_r < CELLS_W);

    lfsr_nxt  = (building && (cand_r > CNT_W'(2))) ? lfsr_step : lfsr_r;
    cand_nxt  = building ? cand_r + CNT_W'(1) : cand_r;
    acc_nxt   = take ? acc_r + CNT_W'(1) : acc_r;
    ready_nxt = ready_r || (cand_r == LAST_CAND);

    wr.fwd_we   = take;
    wr.fwd_addr = acc_r[IDX_W-1:0];
    wr.fwd_data = cand_addr;
    wr.inv_we   = take;
    wr.inv_addr = cand_addr;
    wr.inv_data = acc_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r  <= '0;
      acc_r   <= '0;
      lfsr_r  <= LFSR_SEED;
      ready_r <= 1'b0;
    end else begin
      cand_r  <= cand_nxt;
      acc_r   <= acc_nxt;
      lfsr_r  <= lfsr_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign tables_ready = ready_r;

endmodule

// ----- hw/rtl/sit_lookup.sv -----
module sit_lookup
  import sit_pkg::*;
#(
  parameter int unsigned DATA_CELLS = 1512,
  localparam int unsigned ADDR_W = (DATA_CELLS > 1) ? $clog2(DATA_CELLS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tables_ready,
  input  logic              direction,
  input  logic              in_valid,
  input  logic [IDX_W-1:0]  in_index_in,
  output logic              in_stall,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [IDX_W-1:0]  fwd_rdata,
  input  logic [IDX_W-1:0]  inv_rdata,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_index_out,
  output logic              out_error,
  input  logic              out_stall
);

  localparam logic [CNT_W-1:0] CELLS_W = CNT_W'(DATA_CELLS);

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_err_r;
  logic             s1_dir_r;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_index_r;
  logic             out_error_r;

  logic             out_load;
  logic             s1_free;
  logic             in_acc;
  logic             in_range;
  logic [IDX_W-1:0] lookup_data;

  // handshake and read request
  always_comb begin
    out_load = s1_valid_r && (!out_valid_r || !out_stall);
    s1_free  = !s1_valid_r || out_load;
    in_stall = !tables_ready || !s1_free;
    in_acc   = in_valid && !in_stall;
    in_range = {1'b0, in_index_in} < CELLS_W;
    rd_en    = in_acc && in_range;
    rd_addr  = in_index_in[ADDR_W-1:0];

    lookup_data = s1_dir_r ? inv_rdata : fwd_rdata;

    s1_valid_nxt = in_acc ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_stall ? 1'b0 : out_valid_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request info travelling with the memory read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_err_r <= !in_range;
      s1_dir_r <= direction;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= s1_err_r ? '0 : lookup_data;
      out_error_r <= s1_err_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index_out = out_index_r;
  assign out_error     = out_error_r;

endmodule

// ----- hw/rtl/symbol_interleaver_table_unit.sv -----
// 2K-mode symbol interleaver address translator.
// After reset the unit builds the forward permutation and its inverse into
// two on-chip memories, one candidate address per clock.
// During the build in_stall stays high; configuration writes are taken.
// Input channel (in_valid / in_stall / in_index_in): one cell index per
// request. Result channel (out_valid / out_stall / out_index_out / out_error):
// one result per request, in order. An index at or above DATA_CELLS gives
// out_error = 1 and out_index_out = 0 without a memory read.
// Configuration channel (cfg_valid / cfg_ready / cfg_direction): 0 selects
// the interleave map, 1 the deinterleave map; it is sampled with each
// request and should only be changed while no request is in flight.
// Throughput is one request per cycle while the receiver does not stall, set by
// the single read port of each memory. A request passes the memory read stage
// and then the output register before out_valid rises.
// When the receiver stalls, the result holds in the output register, one
// more request waits on the held memory read data, and then in_stall rises.
// rst_n is synchronous, active low, and restarts the table build.
module symbol_interleaver_table_unit
  import sit_pkg::*;
#(
  parameter int unsigned DATA_CELLS = 1512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [IDX_W-1:0] in_index_in,
  output logic             in_stall,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_index_out,
  output logic             out_error,
  input  logic             out_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_direction
);

  localparam int unsigned ADDR_W = (DATA_CELLS > 1) ? $clog2(DATA_CELLS) : 1;

  sit_wr_t             wr;
  logic                tables_ready;
  logic                direction_r, direction_nxt;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [IDX_W-1:0]    fwd_rdata;
  logic [IDX_W-1:0]    inv_rdata;

  // direction register
  assign cfg_ready     = 1'b1;
  assign direction_nxt = (cfg_valid && cfg_ready) ? cfg_direction : direction_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
    end else begin
      direction_r <= direction_nxt;
    end
  end

  // table build sequencer
  sit_builder #(
    .DATA_CELLS (DATA_CELLS)
  ) u_builder (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr           (wr),
    .tables_ready (tables_ready)
  );

  // forward map memory
  sit_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DATA_CELLS)
  ) u_fwd_ram (
    .clk   (clk),
    .we    (wr.fwd_we),
    .waddr (wr.fwd_addr[ADDR_W-1:0]),
    .wdata (wr.fwd_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (fwd_rdata)
  );

  // inverse map memory
  sit_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DATA_CELLS)
  ) u_inv_ram (
    .clk   (clk),
    .we    (wr.inv_we),
    .waddr (wr.inv_addr[ADDR_W-1:0]),
    .wdata (wr.inv_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (inv_rdata)
  );

  // lookup pipeline
  sit_lookup #(
    .DATA_CELLS (DATA_CELLS)
  ) u_lookup (
    .clk           (clk),
    .rst_n         (rst_n),
    .tables_ready  (tables_ready),
    .direction     (direction_r),
    .in_valid      (in_valid),
    .in_index_in   (in_index_in),
    .in_stall      (in_stall),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .fwd_rdata     (fwd_rdata),
    .inv_rdata     (inv_rdata),
    .out_valid     (out_valid),
    .out_index_out (out_index_out),
    .out_error     (out_error),
    .out_stall     (out_stall)
  );

endmodule

// ----- bench/tb_top.sv -----
module tb_top
  import sit_pkg::*;
();

  localparam int unsigned DATA_CELLS     = 1512;
  localparam int unsigned WATCHDOG_LIMIT = 8000;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned CORNERS        = 9;

  typedef enum logic {
    DIR_INTERLEAVE   = 1'b0,
    DIR_DEINTERLEAVE = 1'b1
  } map_dir_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             error;
  } cell_result_t;

  // edges of the index range, a single-bit value and alternating bit patterns
  localparam logic [IDX_W-1:0] CORNER_CELLS [CORNERS] = '{
    IDX_W'(0), IDX_W'(1), IDX_W'(2), IDX_W'(1024), 11'h2AA, 11'h555,
    IDX_W'(DATA_CELLS - 1), IDX_W'(DATA_CELLS), IDX_W'((1 << IDX_W) - 1)
  };

  // interleaver maps built locally plus the queue of awaited results
  class cell_map_book #(int unsigned CELLS = 1512);
    logic [IDX_W-1:0] interleave_map   [CELLS];
    logic [IDX_W-1:0] deinterleave_map [CELLS];
    map_dir_t         dir;
    cell_result_t     awaited [$];
    int unsigned      mismatches;

    function new();
      logic [LFSR_W-1:0] lfsr;
      logic [LFSR_W-1:0] r;
      logic [IDX_W-1:0]  addr;
      int unsigned       taken;
      lfsr       = LFSR_SEED;
      taken      = 0;
      dir        = DIR_INTERLEAVE;
      mismatches = 0;
      for (int i = 0; i < CANDIDATES; i++) begin
        // first three candidates are fixed, then the lfsr runs
        if (i < 2) begin
          r = '0;
        end else if (i == 2) begin
          r = 10'h001;
        end else begin
          lfsr = {lfsr[0] ^ lfsr[3], lfsr[9:1]};
          r = lfsr;
        end
        // odd candidates take the upper half, R' bits moved to their fixed places
        addr = {i[0], r[2], r[5], r[8], r[3], r[7], r[0], r[1], r[4], r[6], r[9]};
        if (addr < CELLS && taken < CELLS) begin
          interleave_map[taken] = addr;
          deinterleave_map[addr] = IDX_W'(taken);
          taken++;
        end
      end
    endfunction

    function void set_direction(map_dir_t d);
      dir = d;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // work out the result of one accepted request
    function void note_index(logic [IDX_W-1:0] idx);
      cell_result_t res;
      if (idx < CELLS) begin
        res.error = 1'b0;
        res.index = (dir == DIR_DEINTERLEAVE) ? deinterleave_map[idx] : interleave_map[idx];
      end else begin
        res.error = 1'b1;
        res.index = '0;
      end
      awaited.push_back(res);
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // compare one result against the oldest awaited one
    task check_result(logic [IDX_W-1:0] idx, logic err);
      cell_result_t res;
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("result index %0d flag %0b with nothing awaited", idx, err));
        return;
      end
      res = awaited.pop_front();
      if (err !== res.error)
        flag_mismatch($sformatf("out_error %0b, awaited %0b", err, res.error));
      if (idx !== res.index)
        flag_mismatch($sformatf("out_index_out %0d, awaited %0d", idx, res.index));
    endtask
  endclass

  logic             clk;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic [IDX_W-1:0] in_index_in   = '0;
  logic             in_stall;
  logic             out_valid;
  logic [IDX_W-1:0] out_index_out;
  logic             out_error;
  logic             out_stall     = 1'b0;
  logic             cfg_valid     = 1'b0;
  logic             cfg_ready;
  logic             cfg_direction = 1'b0;

  cell_map_book #(DATA_CELLS) book;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned quiet_cycles   = 0;

  symbol_interleaver_table_unit #(
    .DATA_CELLS(DATA_CELLS)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_index_in  (in_index_in),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_index_out(out_index_out),
    .out_error    (out_error),
    .out_stall    (out_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_direction(cfg_direction)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one index, with random idle cycles first, until the request is taken
  task automatic offer_index(input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_index_in <= idx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    book.note_index(idx);
  endtask

  // direction register write, only while nothing is in flight
  task automatic write_direction(input map_dir_t d);
    cfg_valid     <= 1'b1;
    cfg_direction <= d;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    book.set_direction(d);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait for every awaited result, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: check each taken result and stall at random
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0)
        book.check_result(out_index_out, out_error);
      // one long hold-off so the block fills and stalls its input
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any request, result or configuration write taken
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[symbol_interleaver_table_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic [IDX_W-1:0] idx;
    book = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corner indices through both maps, including out of range ones
    write_direction(DIR_INTERLEAVE);
    for (int k = 0; k < CORNERS; k++) offer_index(CORNER_CELLS[k]);
    drain_results();
    write_direction(DIR_DEINTERLEAVE);
    for (int k = 0; k < CORNERS; k++) offer_index(CORNER_CELLS[k]);
    drain_results();

    // random phases with rotating idle patterns and alternating direction
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct  = 25;
          recv_stall_pct = 25;
        end
      endcase
      write_direction((p % 2 == 0) ? DIR_INTERLEAVE : DIR_DEINTERLEAVE);
      if (p == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly valid cells, some from the whole field range
        if ($urandom_range(99) < 80)
          idx = IDX_W'($urandom_range(DATA_CELLS - 1));
        else
          idx = IDX_W'($urandom_range((1 << IDX_W) - 1));
        offer_index(idx);
      end
      drain_results();
    end

    if (book.mismatches == 0) begin
      $display("[symbol_interleaver_table_unit] OK");
    end else begin
      $display("[symbol_interleaver_table_unit] ERROR");
    end
    $finish;
  end

endmodule
